// ===== design/pst_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pst_pkg
// Shared sizes, request codes and the request record that moves from the
// front end through the request queue to the table engine.
// ============================================================================
package pst_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int STRANDS     = 8;

    localparam int ADDR_W     = 32;
    localparam int FP_W       = 32;
    localparam int WEIGHT_W   = 8;
    localparam int IN_STRAND_W = 3;
    localparam int ROW_W      = STRANDS * WEIGHT_W;
    localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int STRAND_W   = (STRANDS > 1) ? $clog2(STRANDS) : 1;

    // depth is a power of two so the pointers wrap on their own
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic REQ_GOSSIP = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_NULL   = 2'd2
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [ADDR_W-1:0]   peer_address;
        logic [ROW_W-1:0]    weights;
        logic [FP_W-1:0]     fingerprint;
        logic [STRAND_W-1:0] strand;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

endpackage

// ===== design/pst_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pst_front
// Accepts requests, classifies them into update, query or null query, packs
// the strand weights into one table row and hands the request to the queue.
// ============================================================================
module pst_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             req_type,
    input  logic [pst_pkg::ADDR_W-1:0]       peer_address,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s0,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s1,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s2,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s3,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s4,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s5,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s6,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s7,
    input  logic [pst_pkg::FP_W-1:0]         gossip_fingerprint,
    input  logic [pst_pkg::IN_STRAND_W-1:0]  query_strand,
    output pst_pkg::cmd_req_t                q_req,
    input  logic                             q_full
);

    logic              valid_reg;
    logic              valid_next;
    pst_pkg::cmd_t     cmd_reg;
    pst_pkg::cmd_t     cmd_next;
    logic              accept;
    logic              move;
    logic [pst_pkg::WEIGHT_W-1:0] w_in [8];

    assign w_in[0] = weight_s0;
    assign w_in[1] = weight_s1;
    assign w_in[2] = weight_s2;
    assign w_in[3] = weight_s3;
    assign w_in[4] = weight_s4;
    assign w_in[5] = weight_s5;
    assign w_in[6] = weight_s6;
    assign w_in[7] = weight_s7;

    assign move   = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;

    always_comb
    begin
        cmd_next = cmd_reg;
        if (accept)
        begin
            cmd_next.peer_address = peer_address;
            cmd_next.fingerprint  = gossip_fingerprint;
            cmd_next.strand       = query_strand[pst_pkg::STRAND_W-1:0];
            for (int i = 0; i < pst_pkg::STRANDS; i++)
            begin
                cmd_next.weights[i*pst_pkg::WEIGHT_W +: pst_pkg::WEIGHT_W] = w_in[i];
            end
            if (req_type == pst_pkg::REQ_GOSSIP)
            begin
                cmd_next.op = pst_pkg::OP_UPDATE;
            end
            else if ({1'b0, query_strand} < (pst_pkg::IN_STRAND_W + 1)'(pst_pkg::STRANDS))
            begin
                cmd_next.op = pst_pkg::OP_QUERY;
            end
            else
            begin
                cmd_next.op = pst_pkg::OP_NULL;
            end
        end
    end

    assign valid_next = accept || (valid_reg && !move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign q_req.valid = valid_reg;
    assign q_req.cmd   = cmd_reg;

endmodule

// ===== design/pst_cmdq.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pst_cmdq
// Short request queue between the front end and the table engine.
// ============================================================================
module pst_cmdq
(
    input  logic               clk,
    input  logic               rst_n,
    input  pst_pkg::cmd_req_t  wr_req,
    output logic               q_full,
    input  logic               rd_take,
    output pst_pkg::cmd_req_t  rd_req
);

    pst_pkg::cmd_t                   slot_reg [pst_pkg::CMDQ_DEPTH];
    logic [pst_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg;
    logic [pst_pkg::CMDQ_PTR_W-1:0]  wr_ptr_next;
    logic [pst_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg;
    logic [pst_pkg::CMDQ_PTR_W-1:0]  rd_ptr_next;
    logic [pst_pkg::CMDQ_CNT_W-1:0]  count_reg;
    logic [pst_pkg::CMDQ_CNT_W-1:0]  count_next;
    logic                            do_wr;
    logic                            do_rd;

    assign q_full = (count_reg == pst_pkg::CMDQ_CNT_W'(pst_pkg::CMDQ_DEPTH));
    assign do_wr  = wr_req.valid && !q_full;
    assign do_rd  = rd_take && (count_reg != '0);

    assign wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_req.cmd;
        end
    end

    assign rd_req.valid = (count_reg != '0);
    assign rd_req.cmd   = slot_reg[rd_ptr_reg];

endmodule

// ===== design/pst_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pst_back
// Table engine: walks the peer table one entry a cycle to find a peer or the
// best authority, writes updates and holds the result register.
// ============================================================================
module pst_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pst_pkg::cmd_req_t            q_req,
    output logic                         q_take,
    output logic                         empty,
    input  logic                         pop,
    output logic [pst_pkg::ADDR_W-1:0]   authority_address,
    output logic                         status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    logic [pst_pkg::ADDR_W-1:0]   addr_mem [pst_pkg::MAX_ENTRIES];
    logic [pst_pkg::ROW_W-1:0]    weight_mem [pst_pkg::MAX_ENTRIES];
    logic [pst_pkg::FP_W-1:0]     fp_mem [pst_pkg::MAX_ENTRIES];

    state_t                       state_reg,     state_next;
    pst_pkg::cmd_t                cmd_reg,       cmd_next;
    logic [pst_pkg::CNT_W-1:0]    scan_idx_reg,  scan_idx_next;
    logic                         pend_reg,      pend_next;
    logic [pst_pkg::IDX_W-1:0]    pend_idx_reg,  pend_idx_next;
    logic [pst_pkg::WEIGHT_W-1:0] best_w_reg,    best_w_next;
    logic [pst_pkg::ADDR_W-1:0]   best_addr_reg, best_addr_next;
    logic                         status_reg,    status_next;
    logic [pst_pkg::IDX_W-1:0]    slot_reg,      slot_next;
    logic                         append_reg,    append_next;
    logic [pst_pkg::CNT_W-1:0]    total_reg,     total_next;
    logic [pst_pkg::MAX_ENTRIES-1:0] healthy_reg, healthy_next;
    logic                         res_valid_reg, res_valid_next;
    logic [pst_pkg::ADDR_W-1:0]   res_addr_reg,  res_addr_next;
    logic                         res_status_reg, res_status_next;

    logic [pst_pkg::ADDR_W-1:0]   addr_rd_reg;
    logic [pst_pkg::ROW_W-1:0]    row_rd_reg;
    logic [pst_pkg::IDX_W-1:0]    rd_idx;
    logic                         issue;
    logic                         hit;
    logic [pst_pkg::WEIGHT_W-1:0] rd_weight;
    logic                         tbl_wr;

    assign rd_idx    = scan_idx_reg[pst_pkg::IDX_W-1:0];
    assign issue     = (scan_idx_reg != total_reg);
    assign hit       = pend_reg && (cmd_reg.op == pst_pkg::OP_UPDATE)
                       && (addr_rd_reg == cmd_reg.peer_address);
    assign rd_weight = row_rd_reg[cmd_reg.strand*pst_pkg::WEIGHT_W +: pst_pkg::WEIGHT_W];
    assign tbl_wr    = (state_reg == S_WRITE);
    assign q_take    = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        best_w_next     = best_w_reg;
        best_addr_next  = best_addr_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        append_next     = append_reg;
        total_next      = total_reg;
        healthy_next    = healthy_reg;
        res_valid_next  = res_valid_reg && !pop;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_req.valid)
                begin
                    cmd_next       = q_req.cmd;
                    scan_idx_next  = '0;
                    best_w_next    = '0;
                    best_addr_next = '0;
                    status_next    = pst_pkg::STATUS_OK;
                    if (q_req.cmd.op == pst_pkg::OP_NULL)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                pend_next     = issue;
                pend_idx_next = rd_idx;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (hit)
                begin
                    pend_next   = 1'b0;
                    slot_next   = pend_idx_reg;
                    append_next = 1'b0;
                    state_next  = S_WRITE;
                end
                else
                begin
                    if (pend_reg && (cmd_reg.op == pst_pkg::OP_QUERY)
                        && healthy_reg[pend_idx_reg] && (rd_weight > best_w_reg))
                    begin
                        best_w_next    = rd_weight;
                        best_addr_next = addr_rd_reg;
                    end
                    if (!issue && !pend_reg)
                    begin
                        if (cmd_reg.op != pst_pkg::OP_UPDATE)
                        begin
                            state_next = S_DONE;
                        end
                        else if (total_reg == pst_pkg::CNT_W'(pst_pkg::MAX_ENTRIES))
                        begin
                            status_next = pst_pkg::STATUS_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            slot_next   = total_reg[pst_pkg::IDX_W-1:0];
                            append_next = 1'b1;
                            state_next  = S_WRITE;
                        end
                    end
                end
            end
            S_WRITE:
            begin
                if (append_reg)
                begin
                    healthy_next[slot_reg] = 1'b1;
                    total_next             = total_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_valid_next  = 1'b1;
                    res_addr_next   = best_addr_reg;
                    res_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            total_reg     <= '0;
            healthy_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            total_reg     <= total_next;
            healthy_reg   <= healthy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        best_w_reg     <= best_w_next;
        best_addr_reg  <= best_addr_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        append_reg     <= append_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr && append_reg)
        begin
            addr_mem[slot_reg] <= cmd_reg.peer_address;
        end
        addr_rd_reg <= addr_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            weight_mem[slot_reg] <= cmd_reg.weights;
        end
        row_rd_reg <= weight_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            fp_mem[slot_reg] <= cmd_reg.fingerprint;
        end
    end

    assign empty             = !res_valid_reg;
    assign authority_address = res_addr_reg;
    assign status            = res_status_reg;

endmodule

// ===== design/peer_strand_authority_table.sv =====
`timescale 1ns / 1ps
// Path from push to result: front stage, queue, walk of the table at one entry a
// cycle with registered memory reads, write for a gossip that hits or appends,
// result register. The engine works on one request at a time: it takes the next
// request from the queue only once it is back in idle, while the front stage and
// the queue hold the requests behind it.
// Reset: rst_n clears the queues, the healthy bits and the entry count at once.
// ============================================================================
// peer_strand_authority_table
// Peer table with gossip updates and per-strand authority queries.
// ============================================================================
module peer_strand_authority_table
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             req_type,
    input  logic [pst_pkg::ADDR_W-1:0]       peer_address,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s0,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s1,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s2,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s3,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s4,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s5,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s6,
    input  logic [pst_pkg::WEIGHT_W-1:0]     weight_s7,
    input  logic [pst_pkg::FP_W-1:0]         gossip_fingerprint,
    input  logic [pst_pkg::IN_STRAND_W-1:0]  query_strand,
    output logic                             empty,
    input  logic                             pop,
    output logic [pst_pkg::ADDR_W-1:0]       authority_address,
    output logic                             status
);

    pst_pkg::cmd_req_t  front_req;
    pst_pkg::cmd_req_t  back_req;
    logic               q_full;
    logic               q_take;

    pst_front u_front
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .req_type           (req_type),
        .peer_address       (peer_address),
        .weight_s0          (weight_s0),
        .weight_s1          (weight_s1),
        .weight_s2          (weight_s2),
        .weight_s3          (weight_s3),
        .weight_s4          (weight_s4),
        .weight_s5          (weight_s5),
        .weight_s6          (weight_s6),
        .weight_s7          (weight_s7),
        .gossip_fingerprint (gossip_fingerprint),
        .query_strand       (query_strand),
        .q_req              (front_req),
        .q_full             (q_full)
    );

    pst_cmdq u_cmdq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_req  (front_req),
        .q_full  (q_full),
        .rd_take (q_take),
        .rd_req  (back_req)
    );

    pst_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_req             (back_req),
        .q_take            (q_take),
        .empty             (empty),
        .pop               (pop),
        .authority_address (authority_address),
        .status            (status)
    );

endmodule
